// ===== src/psa_pkg.sv =====
// Shared types and constants for the priority scheduler with aging.
package psa_pkg;

   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_ADD     = 2'd1,
      OP_REMOVE  = 2'd2,
      OP_REQUEUE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   localparam logic [0:0] REG_THRESHOLD = 1'b0;
   localparam logic [0:0] REG_IDLE_ID   = 1'b1;

   localparam logic [3:0] STARVE_RESET = 4'd5;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SEARCH_RD,
      S_SEARCH_CHK,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_PUSH,
      S_TICK_PICK,
      S_POP_RD,
      S_POP_SHIFT_WR,
      S_DONE
   } state_type;

endpackage

// ===== src/psa_if.sv =====
// Valid/ready channel interface carrying one item per handshake.
interface psa_if #(parameter int W = 8) (input logic clock);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== src/priority_scheduler_with_aging_unit.sv =====
// Flow: a tick that keeps its task goes from accept straight to the result state, an add
// passes the push state first. Remove and requeue scan the queued entries one by one and
// compact by reading and writing each moved entry; a switching tick pops one level the
// same way. Throughput: one item at a time; the next item is accepted once the result is
// registered. Reset: counters, current task and control clear at once; queue memory is
// not cleared, since only entries below a count are read.
module priority_scheduler_with_aging_unit
   import psa_pkg::*;
#(
   parameter int TOP_LEVEL   = 7,
   parameter int QUEUE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [5:0]  req_task_id,
   input  logic [2:0]  req_task_priority,
   input  logic        req_still_running,
   input  logic        req_task_is_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_running_id,
   output logic [2:0]  rsp_running_priority,
   output logic        rsp_switched,
   output logic [1:0]  rsp_status,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int NL = TOP_LEVEL + 1;
   localparam int LW = 3;
   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [LW-1:0] TOP = LW'(TOP_LEVEL);

   // Queue memory: one word per (level, slot).
   logic [5:0] mem [NL*(2**AW)];
   logic       mem_we;
   logic [LW+AW-1:0] mem_waddr, mem_raddr;
   logic [5:0] mem_wdata, mem_rdata;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      mem_rdata <= mem[mem_raddr];
   end

   function automatic logic [LW+AW-1:0] maddr(input logic [LW-1:0] l, input logic [CW-1:0] i);
      maddr = {l, i[AW-1:0]};
   endfunction

   state_type state_ff, state_in;
   logic [3:0]  thr_ff, thr_in;
   logic [5:0]  idle_ff, idle_in;
   logic [CW-1:0] cnt_ff [NL];
   logic [CW-1:0] cnt_in [NL];
   logic [3:0]  stv_ff [NL];
   logic [3:0]  stv_in [NL];
   logic [5:0]  cur_ff, cur_in;
   logic [LW-1:0] curl_ff, curl_in;
   logic [7:0]  qc_ff, qc_in;
   logic [8:0]  ql_ff, ql_in;
   op_type      op_ff, op_in;
   logic [5:0]  id_ff, id_in;
   logic [LW-1:0] lv_ff, lv_in;      // level for push / first search
   logic [LW-1:0] sl_ff, sl_in;      // level being searched or compacted
   logic [3:0]  step_ff, step_in;    // search order position
   logic [CW-1:0] ix_ff, ix_in;
   logic [1:0]  st_ff, st_in;
   logic        sw_ff, sw_in;
   logic        ov_ff, ov_in;
   logic [5:0]  res_id_ff;
   logic [LW-1:0] res_lv_ff;
   logic        res_sw_ff;
   logic [1:0]  res_st_ff;

   logic req_fire, rsp_fire, csr_wr;
   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = ov_ff;
   assign rsp_fire  = ov_ff && rsp_ready;
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_IDLE_ID) csr_prdata[5:0] = idle_ff;
      else csr_prdata[3:0] = thr_ff;
   end

   // Search order position to level: own level first, then others ascending.
   function automatic logic [LW-1:0] ord_lv(input logic [3:0] s, input logic [LW-1:0] f);
      logic [3:0] k;
      k = s - 4'd1;
      if (s == 4'd0) ord_lv = f;
      else if (k[LW-1:0] >= f) ord_lv = k[LW-1:0] + LW'(1);
      else ord_lv = k[LW-1:0];
   endfunction

   always_comb begin
      logic [7:0] q;
      state_in = state_ff;
      thr_in = thr_ff; idle_in = idle_ff;
      cnt_in = cnt_ff; stv_in = stv_ff;
      cur_in = cur_ff; curl_in = curl_ff; qc_in = qc_ff; ql_in = ql_ff;
      op_in = op_ff; id_in = id_ff; lv_in = lv_ff; sl_in = sl_ff;
      step_in = step_ff; ix_in = ix_ff;
      st_in = st_ff; sw_in = sw_ff; ov_in = ov_ff;
      mem_we = 1'b0; mem_waddr = '0; mem_wdata = '0; mem_raddr = '0;
      q = (qc_ff == 8'hFF) ? qc_ff : qc_ff + 8'd1;
      if (rsp_fire) ov_in = 1'b0;
      if (csr_wr) begin
         if (csr_paddr[2] == REG_IDLE_ID) idle_in = csr_pwdata[5:0];
         else thr_in = csr_pwdata[3:0];
      end
      unique case (state_ff)
         S_IDLE: if (req_fire) begin
            op_in = op_type'(req_operation);
            id_in = req_task_id;
            lv_in = (req_task_priority > TOP) ? TOP : req_task_priority;
            st_in = ST_OK; sw_in = 1'b0;
            unique case (op_type'(req_operation))
               OP_TICK: begin
                  if (req_still_running && {1'b0, q} < ql_ff) begin
                     qc_in = q; state_in = S_DONE;
                  end else if (req_still_running) begin
                     lv_in = curl_ff; id_in = cur_ff; state_in = S_PUSH;
                  end else state_in = S_TICK_PICK;
               end
               OP_ADD: state_in = S_PUSH;
               OP_REMOVE: begin
                  step_in = '0; ix_in = '0; state_in = S_SEARCH_RD;
               end
               default: begin
                  step_in = '0; ix_in = '0;
                  state_in = req_task_is_ready ? S_SEARCH_RD : S_DONE;
               end
            endcase
         end
         S_SEARCH_RD: begin
            sl_in = ord_lv(step_ff, lv_ff);
            if (ix_ff < cnt_ff[ord_lv(step_ff, lv_ff)]) begin
               mem_raddr = maddr(ord_lv(step_ff, lv_ff), ix_ff);
               state_in = S_SEARCH_CHK;
            end else if (step_ff == 4'(TOP_LEVEL)) begin
               st_in = ST_NOT_FOUND; state_in = S_DONE;
            end else begin
               step_in = step_ff + 4'd1; ix_in = '0;
            end
         end
         S_SEARCH_CHK: begin
            if (mem_rdata == id_ff) begin
               cnt_in[sl_ff] = cnt_ff[sl_ff] - CW'(1);
               state_in = S_SHIFT_RD;
            end else begin
               ix_in = ix_ff + CW'(1); state_in = S_SEARCH_RD;
            end
         end
         // Compaction: move entry ix+1 down to ix, reading it in S_SHIFT_RD and writing it in S_SHIFT_WR.
         S_SHIFT_RD: begin
            if (ix_ff + CW'(1) < cnt_ff[sl_ff] + CW'(1) && ix_ff < cnt_ff[sl_ff]) begin
               mem_raddr = maddr(sl_ff, ix_ff + CW'(1));
               state_in = S_SHIFT_WR;
            end else if (op_ff == OP_REQUEUE) state_in = S_PUSH;
            else if (op_ff == OP_TICK) state_in = S_DONE;
            else state_in = S_DONE;
         end
         S_SHIFT_WR: begin
            mem_we = 1'b1; mem_waddr = maddr(sl_ff, ix_ff); mem_wdata = mem_rdata;
            ix_in = ix_ff + CW'(1);
            state_in = S_SHIFT_RD;
         end
         S_PUSH: begin
            if (cnt_ff[lv_ff] >= CW'(QUEUE_DEPTH)) st_in = ST_FULL;
            else begin
               mem_we = 1'b1; mem_waddr = maddr(lv_ff, cnt_ff[lv_ff]); mem_wdata = id_ff;
               cnt_in[lv_ff] = cnt_ff[lv_ff] + CW'(1);
            end
            state_in = (op_ff == OP_TICK) ? S_TICK_PICK : S_DONE;
         end
         S_TICK_PICK: begin
            // Age, then choose; aging result is computed inline.
            logic [3:0] a [NL];
            logic [LW-1:0] pl;
            logic pf, sf;
            pf = 1'b0; sf = 1'b0; pl = '0;
            for (int l = 0; l < NL; l++) begin
               if (cnt_ff[l] != '0) a[l] = (stv_ff[l] < thr_ff) ? stv_ff[l] + 4'd1 : stv_ff[l];
               else a[l] = '0;
               stv_in[l] = a[l];
            end
            for (int l = 0; l < NL; l++)
               if (cnt_ff[l] != '0 && a[l] >= thr_ff) begin sf = 1'b1; pl = LW'(l); end
            if (!sf)
               for (int l = 0; l < NL; l++)
                  if (cnt_ff[l] != '0) begin pf = 1'b1; pl = LW'(l); end
            sw_in = 1'b1; qc_in = '0;
            if (sf || pf) begin
               sl_in = pl; curl_in = pl; ix_in = '0;
               stv_in[pl] = '0;
               mem_raddr = maddr(pl, '0);
               ql_in = 9'd1 << pl;
               state_in = S_POP_RD;
            end else begin
               cur_in = idle_ff; curl_in = '0; ql_in = 9'd1; state_in = S_DONE;
            end
         end
         S_POP_RD: begin
            cur_in = mem_rdata;
            cnt_in[sl_ff] = cnt_ff[sl_ff] - CW'(1);
            state_in = S_SHIFT_RD;
         end
         S_POP_SHIFT_WR: state_in = S_DONE;
         S_DONE: begin
            if (!ov_ff || rsp_fire) begin
               ov_in = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         thr_ff <= STARVE_RESET; idle_ff <= '0;
         for (int l = 0; l < NL; l++) begin cnt_ff[l] <= '0; stv_ff[l] <= '0; end
         cur_ff <= '0; curl_ff <= '0; qc_ff <= '0; ql_ff <= '0;
         ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         thr_ff <= thr_in; idle_ff <= idle_in;
         cnt_ff <= cnt_in; stv_ff <= stv_in;
         cur_ff <= cur_in; curl_ff <= curl_in; qc_ff <= qc_in; ql_ff <= ql_in;
         ov_ff <= ov_in;
      end
      op_ff <= op_in; id_ff <= id_in; lv_ff <= lv_in; sl_ff <= sl_in;
      step_ff <= step_in; ix_ff <= ix_in;
      st_ff <= st_in; sw_ff <= sw_in;
   end

   // The result is captured when it is handed over, so the next item may start at once.
   always_ff @(posedge clock) begin
      if (state_ff == S_DONE && (!ov_ff || rsp_fire)) begin
         res_id_ff <= cur_ff;
         res_lv_ff <= curl_ff;
         res_sw_ff <= sw_ff;
         res_st_ff <= st_ff;
      end
   end

   assign rsp_running_id = res_id_ff;
   assign rsp_running_priority = res_lv_ff;
   assign rsp_switched = res_sw_ff;
   assign rsp_status = res_st_ff;

`ifndef SYNTHESIS
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_running_id))
      else $error("result dropped while stalled");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_ready)
      else $error("item accepted while busy");
   a_switch_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_switched |-> rsp_status != ST_NOT_FOUND)
      else $error("switch flagged with a not-found status");
`endif

endmodule

// ===== verif/psa_checker.sv =====
// Monitor, scheduler predictor and result checker for the priority scheduler.
`timescale 1ns / 1ps

module psa_checker
   import psa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   psa_if              req_ch,
   psa_if              rsp_ch,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic        csr_pready,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output int          errors,
   output int          pending
);

   localparam int LEVELS = 8;
   localparam int DEPTH  = 64;

   typedef struct packed {
      logic [5:0] running_id;
      logic [2:0] running_priority;
      logic       switched;
      status_type status;
   } sched_result_type;

   logic [5:0] level_q [LEVELS][$];
   logic [3:0] starve [LEVELS];
   logic [3:0] threshold;
   logic [5:0] idle_id;
   logic [5:0] cur_task;
   logic [2:0] cur_level;
   logic [7:0] quantum;
   int         quantum_limit;
   sched_result_type expected_results[$];

   function automatic status_type append_task(int lv, logic [5:0] id);
      if (level_q[lv].size() >= DEPTH) return ST_FULL;
      level_q[lv].push_back(id);
      return ST_OK;
   endfunction

   function automatic bit drop_task(int lv, logic [5:0] id);
      for (int i = 0; i < level_q[lv].size(); i++) begin
         if (level_q[lv][i] == id) begin
            level_q[lv].delete(i);
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // The task's own level is searched first, then the rest in ascending order.
   function automatic bit find_and_drop(int first, logic [5:0] id);
      if (drop_task(first, id)) return 1'b1;
      for (int lv = 0; lv < LEVELS; lv++)
         if (lv != first && drop_task(lv, id)) return 1'b1;
      return 1'b0;
   endfunction

   function automatic void choose_next();
      for (int lv = LEVELS - 1; lv >= 0; lv--) begin
         if (starve[lv] >= threshold && level_q[lv].size() != 0) begin
            cur_task = level_q[lv].pop_front();
            starve[lv] = '0;
            cur_level = lv[2:0];
            return;
         end
      end
      for (int lv = LEVELS - 1; lv >= 0; lv--) begin
         if (level_q[lv].size() != 0) begin
            cur_task = level_q[lv].pop_front();
            starve[lv] = '0;
            cur_level = lv[2:0];
            return;
         end
      end
      cur_task = idle_id;
      cur_level = '0;
   endfunction

   function automatic sched_result_type schedule_step(logic [12:0] d);
      op_type     op;
      logic [5:0] id;
      int         lv;
      logic       running;
      logic       ready;
      logic [7:0] q;
      status_type st;
      logic       sw;
      op = op_type'(d[12:11]);
      id = d[10:5];
      lv = d[4:2];
      running = d[1];
      ready = d[0];
      st = ST_OK;
      sw = 1'b0;
      case (op)
         OP_TICK: begin
            q = (quantum == 8'hff) ? quantum : quantum + 8'd1;
            if (running && int'(q) < quantum_limit) begin
               quantum = q;
            end else begin
               if (running) st = append_task(cur_level, cur_task);
               for (int l = 0; l < LEVELS; l++) begin
                  if (level_q[l].size() != 0) begin
                     if (starve[l] < threshold) starve[l]++;
                  end else begin
                     starve[l] = '0;
                  end
               end
               choose_next();
               quantum = '0;
               quantum_limit = 1 << cur_level;
               sw = 1'b1;
            end
         end
         OP_ADD: st = append_task(lv, id);
         OP_REMOVE: st = find_and_drop(lv, id) ? ST_OK : ST_NOT_FOUND;
         default: begin
            if (ready) st = find_and_drop(lv, id) ? append_task(lv, id) : ST_NOT_FOUND;
         end
      endcase
      return '{cur_task, cur_level, sw, st};
   endfunction

   assign pending = expected_results.size();

   always @(posedge clock) begin
      sched_result_type got;
      sched_result_type want;
      if (reset) begin
         for (int l = 0; l < LEVELS; l++) begin
            level_q[l].delete();
            starve[l] = '0;
         end
         threshold = STARVE_RESET;
         idle_id = '0;
         cur_task = '0;
         cur_level = '0;
         quantum = '0;
         quantum_limit = 0;
         expected_results.delete();
         errors <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_IDLE_ID) idle_id = csr_pwdata[5:0];
            else threshold = csr_pwdata[3:0];
         end
         if (req_ch.valid && req_ch.ready)
            expected_results.push_back(schedule_step(req_ch.data));
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.data;
            if (expected_results.size() == 0) begin
               $error("result item with no expectation waiting: %h", got);
               errors <= errors + 1;
            end else begin
               want = expected_results.pop_front();
               if (got != want) errors <= errors + 1;
               if (got.running_id != want.running_id)
                  $error("running_id expected %0d actual %0d",
                         want.running_id, got.running_id);
               if (got.running_priority != want.running_priority)
                  $error("running_priority expected %0d actual %0d",
                         want.running_priority, got.running_priority);
               if (got.switched != want.switched)
                  $error("switched expected %0d actual %0d", want.switched, got.switched);
               if (got.status != want.status)
                  $error("status expected %0d actual %0d", want.status, got.status);
            end
         end
      end
   end

endmodule

// ===== verif/priority_scheduler_with_aging_unit_tb.sv =====
// Top of the scheduler testbench: clock, reset, stimulus, configuration and verdict.
`timescale 1ns / 1ps

module priority_scheduler_with_aging_unit_tb
   import psa_pkg::*;
;

   localparam int CYCLE_LIMIT = 8000000;
   localparam int PHASE_ITEMS = 475;
   localparam logic [2:0] ADDR_THRESHOLD = {REG_THRESHOLD, 2'b00};
   localparam logic [2:0] ADDR_IDLE_ID   = {REG_IDLE_ID, 2'b00};

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          errors;
   int          pending;
   int          cycles = 0;
   int          burst_left;

   psa_if #(.W(13)) req (.clock(clock));
   psa_if #(.W(12)) rsp (.clock(clock));

   priority_scheduler_with_aging_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req.valid),
      .req_ready(req.ready),
      .req_operation(req.data[12:11]),
      .req_task_id(req.data[10:5]),
      .req_task_priority(req.data[4:2]),
      .req_still_running(req.data[1]),
      .req_task_is_ready(req.data[0]),
      .rsp_valid(rsp.valid),
      .rsp_ready(rsp.ready),
      .rsp_running_id(rsp.data[11:6]),
      .rsp_running_priority(rsp.data[5:3]),
      .rsp_switched(rsp.data[2]),
      .rsp_status(rsp.data[1:0]),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   psa_checker checker_i (
      .clock(clock),
      .reset(reset),
      .req_ch(req),
      .rsp_ch(rsp),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_pready(csr_pready),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .errors(errors),
      .pending(pending)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("priority_scheduler_with_aging_unit test failed");
         $finish;
      end
   end

   // The receiver alternates between always ready, random stalls and long stalls.
   always @(posedge clock) begin
      case ((cycles / 300) % 3)
         0: rsp.ready <= 1'b1;
         1: rsp.ready <= ($urandom_range(0, 9) < 7);
         default: rsp.ready <= ($urandom_range(0, 15) == 0);
      endcase
   end

   task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Valid stays high across a burst; a gap of random length follows each burst.
   task automatic send_item(input op_type op, input logic [5:0] id, input logic [2:0] lv,
                            input logic running, input logic rdy);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req.valid <= 1'b1;
      req.data <= {op, id, lv, running, rdy};
      do @(posedge clock); while (!req.ready);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      burst_left = 0;
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic random_phase(input int count);
      int         pick;
      logic [2:0] hot;
      hot = 3'($urandom_range(0, 7));
      for (int n = 0; n < count; n++) begin
         // Open each phase with a flood into one level so that it fills up.
         if (n < 70) begin
            send_item(OP_ADD, 6'($urandom_range(0, 63)), hot, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
               send_item(OP_TICK, 6'($urandom_range(0, 63)), 3'($urandom_range(0, 7)),
                         ($urandom_range(0, 3) != 0), 1'($urandom_range(0, 1)));
            else if (pick < 65)
               send_item(OP_ADD, 6'($urandom_range(0, 63)),
                         ($urandom_range(0, 1) ? hot : 3'($urandom_range(0, 7))),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            else if (pick < 85)
               send_item(OP_REMOVE, 6'($urandom_range(0, 63)), 3'($urandom_range(0, 7)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            else
               send_item(OP_REQUEUE, 6'($urandom_range(0, 63)), 3'($urandom_range(0, 7)),
                         1'($urandom_range(0, 1)), ($urandom_range(0, 3) != 0));
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req.valid = 1'b0;
      req.data = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      burst_left = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_reg(ADDR_THRESHOLD, 32'd5);
      write_reg(ADDR_IDLE_ID, 32'd0);
      // Directed: first tick requeues and re-picks the running task, not-found paths, search order, requeue.
      send_item(OP_TICK, 6'd0, 3'd0, 1'b1, 1'b0);
      send_item(OP_ADD, 6'd63, 3'd7, 1'b0, 1'b0);
      send_item(OP_ADD, 6'd0, 3'd0, 1'b0, 1'b1);
      send_item(OP_REQUEUE, 6'd10, 3'd2, 1'b0, 1'b1);
      send_item(OP_REQUEUE, 6'd63, 3'd2, 1'b1, 1'b0);
      send_item(OP_REMOVE, 6'd33, 3'd4, 1'b0, 1'b0);
      send_item(OP_ADD, 6'd5, 3'd3, 1'b0, 1'b0);
      send_item(OP_ADD, 6'd5, 3'd5, 1'b0, 1'b0);
      send_item(OP_REMOVE, 6'd5, 3'd5, 1'b0, 1'b0);
      send_item(OP_REMOVE, 6'd5, 3'd0, 1'b0, 1'b0);
      send_item(OP_REQUEUE, 6'd63, 3'd2, 1'b0, 1'b1);
      send_item(OP_TICK, 6'd63, 3'd7, 1'b1, 1'b1);
      send_item(OP_TICK, 6'd0, 3'd0, 1'b1, 1'b0);
      send_item(OP_TICK, 6'd0, 3'd0, 1'b0, 1'b0);
      send_item(OP_TICK, 6'd0, 3'd0, 1'b0, 1'b0);
      send_item(OP_ADD, 6'd21, 3'd1, 1'b1, 1'b1);
      send_item(OP_TICK, 6'd0, 3'd0, 1'b1, 1'b0);
      send_item(OP_TICK, 6'd0, 3'd0, 1'b1, 1'b0);
      random_phase(PHASE_ITEMS - 18);
      drain();

      write_reg(ADDR_THRESHOLD, 32'd1);
      write_reg(ADDR_IDLE_ID, 32'd63);
      random_phase(PHASE_ITEMS);
      drain();

      write_reg(ADDR_THRESHOLD, 32'd15);
      write_reg(ADDR_IDLE_ID, 32'($urandom_range(0, 63)));
      random_phase(PHASE_ITEMS);
      drain();

      write_reg(ADDR_THRESHOLD, 32'd0);
      write_reg(ADDR_IDLE_ID, 32'd42);
      random_phase(PHASE_ITEMS / 2);
      drain();
      write_reg(ADDR_THRESHOLD, 32'($urandom_range(1, 15)));
      random_phase(PHASE_ITEMS / 2);
      drain();

      if (errors == 0) begin
         $display("priority_scheduler_with_aging_unit test passed");
      end else begin
         $display("priority_scheduler_with_aging_unit test failed");
      end
      $finish;
   end

endmodule
